>>> sv/biq_pkg.sv
`timescale 1ns / 1ps

package biq_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int COEF_FRAC_BITS = 20;
    localparam int COEF_WIDTH     = 24;
    localparam int DELAY_WIDTH    = 48;
    localparam int NUM_COEFS      = 5;
    localparam int ADDR_WIDTH     = 5;
    localparam int DATA_WIDTH     = 32;

    localparam int Y_WIDTH    = DELAY_WIDTH - COEF_FRAC_BITS + 1;
    localparam int OPB_WIDTH  = (Y_WIDTH > SAMPLE_WIDTH) ? Y_WIDTH : SAMPLE_WIDTH;
    localparam int PROD_WIDTH = COEF_WIDTH + OPB_WIDTH;
    localparam int ACC_WIDTH  = PROD_WIDTH + 3;

    localparam logic [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1) << COEF_FRAC_BITS;
    localparam logic [ACC_WIDTH-1:0]  ROUND_HALF = ACC_WIDTH'(1) << (COEF_FRAC_BITS - 1);

    typedef enum logic [2:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [COEF_WIDTH-1:0] b0;
        logic [COEF_WIDTH-1:0] b1;
        logic [COEF_WIDTH-1:0] b2;
        logic [COEF_WIDTH-1:0] a1;
        logic [COEF_WIDTH-1:0] a2;
    } coefs_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MB0,
        ST_ACC,
        ST_RND,
        ST_MA1,
        ST_N1,
        ST_MA2,
        ST_N2
    } state_t;

    typedef enum logic [2:0] {
        MUL_B0,
        MUL_B1,
        MUL_B2,
        MUL_A1,
        MUL_A2
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_SAT_D1,
        ACC_ADD_D2,
        ACC_LOAD
    } acc_op_t;

    typedef struct packed {
        logic     load_x;
        logic     mul_en;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     y_en;
        logic     d1_en;
        logic     d2_en;
        logic     out_en;
    } ctl_t;

    function automatic logic [DELAY_WIDTH-1:0] sat_delay(input logic [ACC_WIDTH-1:0] v);
        logic [ACC_WIDTH-DELAY_WIDTH:0] upper;
        logic [DELAY_WIDTH-1:0]         res;
        upper = v[ACC_WIDTH-1:DELAY_WIDTH-1];
        if ((&upper) || (~|upper))
        begin
            res = v[DELAY_WIDTH-1:0];
        end
        else if (v[ACC_WIDTH-1])
        begin
            res = {1'b1, {(DELAY_WIDTH-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(DELAY_WIDTH-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

>>> sv/biq_regs.sv
`timescale 1ns / 1ps

module biq_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [biq_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [biq_pkg::DATA_WIDTH-1:0] pwdata,
    output logic [biq_pkg::DATA_WIDTH-1:0] prdata,
    output logic                           pready,
    output biq_pkg::coefs_t                coefs
);
    import biq_pkg::*;

    coefs_t   coefs_reg;
    reg_idx_t idx;
    logic     wr_en;
    logic [COEF_WIDTH-1:0] rd_coef;

    assign idx    = reg_idx_t'(paddr[ADDR_WIDTH-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign coefs  = coefs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefs_reg.b0 <= COEF_ONE;
            coefs_reg.b1 <= '0;
            coefs_reg.b2 <= '0;
            coefs_reg.a1 <= '0;
            coefs_reg.a2 <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_B0:  coefs_reg.b0 <= pwdata[COEF_WIDTH-1:0];
                REG_B1:  coefs_reg.b1 <= pwdata[COEF_WIDTH-1:0];
                REG_B2:  coefs_reg.b2 <= pwdata[COEF_WIDTH-1:0];
                REG_A1:  coefs_reg.a1 <= pwdata[COEF_WIDTH-1:0];
                REG_A2:  coefs_reg.a2 <= pwdata[COEF_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_B0:  rd_coef = coefs_reg.b0;
            REG_B1:  rd_coef = coefs_reg.b1;
            REG_B2:  rd_coef = coefs_reg.b2;
            REG_A1:  rd_coef = coefs_reg.a1;
            REG_A2:  rd_coef = coefs_reg.a2;
            default: rd_coef = '0;
        endcase
    end

    assign prdata = {{(DATA_WIDTH-COEF_WIDTH){rd_coef[COEF_WIDTH-1]}}, rd_coef};

endmodule

>>> sv/biq_ctrl.sv
`timescale 1ns / 1ps

module biq_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output biq_pkg::ctl_t ctl
);
    import biq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ctl            = '0;
        ctl.mul_sel    = MUL_B0;
        ctl.acc_op     = ACC_HOLD;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctl.load_x = in_valid;
                if (in_valid)
                begin
                    state_next = ST_MB0;
                end
            end
            ST_MB0:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MUL_B0;
                state_next  = ST_ACC;
            end
            ST_ACC:
            begin
                ctl.acc_op  = ACC_SAT_D1;
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MUL_B1;
                state_next  = ST_RND;
            end
            ST_RND:
            begin
                ctl.y_en   = 1'b1;
                ctl.acc_op = ACC_ADD_D2;
                state_next = ST_MA1;
            end
            ST_MA1:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MUL_A1;
                state_next  = ST_N1;
            end
            ST_N1:
            begin
                ctl.d1_en   = 1'b1;
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MUL_B2;
                state_next  = ST_MA2;
            end
            ST_MA2:
            begin
                ctl.acc_op  = ACC_LOAD;
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MUL_A2;
                state_next  = ST_N2;
            end
            ST_N2:
            begin
                if (out_free)
                begin
                    ctl.d2_en      = 1'b1;
                    ctl.out_en     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/biq_datapath.sv
`timescale 1ns / 1ps

module biq_datapath
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  biq_pkg::ctl_t                           ctl,
    input  biq_pkg::coefs_t                         coefs,
    input  logic signed [biq_pkg::SAMPLE_WIDTH-1:0] sample_in,
    output logic signed [biq_pkg::SAMPLE_WIDTH-1:0] sample_out,
    output logic                                    clipped
);
    import biq_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [OPB_WIDTH-1:0]    y_reg;
    logic signed [PROD_WIDTH-1:0]   prod_reg;
    logic [ACC_WIDTH-1:0]           acc_reg;
    logic [DELAY_WIDTH-1:0]         d1_reg;
    logic [DELAY_WIDTH-1:0]         d2_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_reg;
    logic                           clip_reg;

    logic signed [COEF_WIDTH-1:0]   mul_a;
    logic signed [OPB_WIDTH-1:0]    mul_b;
    logic signed [OPB_WIDTH-1:0]    x_ext;
    logic signed [PROD_WIDTH-1:0]   prod_w;
    logic [ACC_WIDTH-1:0]           prod_ext;
    logic [ACC_WIDTH-1:0]           d1_ext;
    logic [ACC_WIDTH-1:0]           d2_ext;
    logic [ACC_WIDTH-1:0]           diff;
    logic [ACC_WIDTH-1:0]           round_sum;
    logic [DELAY_WIDTH-1:0]         d1_sum_sat;
    logic [OPB_WIDTH-SAMPLE_WIDTH:0] y_upper;
    logic signed [SAMPLE_WIDTH-1:0] out_sat;
    logic                           out_clip;

    assign x_ext = {{(OPB_WIDTH-SAMPLE_WIDTH){x_reg[SAMPLE_WIDTH-1]}}, x_reg};

    always_comb
    begin
        unique case (ctl.mul_sel)
            MUL_B0:
            begin
                mul_a = coefs.b0;
                mul_b = x_ext;
            end
            MUL_B1:
            begin
                mul_a = coefs.b1;
                mul_b = x_ext;
            end
            MUL_B2:
            begin
                mul_a = coefs.b2;
                mul_b = x_ext;
            end
            MUL_A1:
            begin
                mul_a = coefs.a1;
                mul_b = y_reg;
            end
            MUL_A2:
            begin
                mul_a = coefs.a2;
                mul_b = y_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_w     = mul_a * mul_b;
    assign prod_ext   = {{(ACC_WIDTH-PROD_WIDTH){prod_reg[PROD_WIDTH-1]}}, prod_reg};
    assign d1_ext     = {{(ACC_WIDTH-DELAY_WIDTH){d1_reg[DELAY_WIDTH-1]}}, d1_reg};
    assign d2_ext     = {{(ACC_WIDTH-DELAY_WIDTH){d2_reg[DELAY_WIDTH-1]}}, d2_reg};
    assign diff       = acc_reg - prod_ext;
    assign round_sum  = acc_reg + ROUND_HALF;
    assign d1_sum_sat = sat_delay(prod_ext + d1_ext);

    // clamp y to the sample range
    assign y_upper = y_reg[OPB_WIDTH-1:SAMPLE_WIDTH-1];
    always_comb
    begin
        if ((&y_upper) || (~|y_upper))
        begin
            out_sat  = y_reg[SAMPLE_WIDTH-1:0];
            out_clip = 1'b0;
        end
        else if (y_reg[OPB_WIDTH-1])
        begin
            out_sat  = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
            out_clip = 1'b1;
        end
        else
        begin
            out_sat  = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
            out_clip = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_reg <= '0;
            d2_reg <= '0;
        end
        else
        begin
            if (ctl.d1_en)
            begin
                d1_reg <= sat_delay(diff);
            end
            if (ctl.d2_en)
            begin
                d2_reg <= sat_delay(diff);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_x)
        begin
            x_reg <= sample_in;
        end
        if (ctl.mul_en)
        begin
            prod_reg <= prod_w;
        end
        if (ctl.y_en)
        begin
            y_reg <= round_sum[COEF_FRAC_BITS +: OPB_WIDTH];
        end
        case (ctl.acc_op)
            ACC_SAT_D1:
            begin
                acc_reg <= {{(ACC_WIDTH-DELAY_WIDTH){d1_sum_sat[DELAY_WIDTH-1]}}, d1_sum_sat};
            end
            ACC_ADD_D2: acc_reg <= prod_ext + d2_ext;
            ACC_LOAD:   acc_reg <= prod_ext;
            default:    ;
        endcase
        if (ctl.out_en)
        begin
            out_reg  <= out_sat;
            clip_reg <= out_clip;
        end
    end

    assign sample_out = out_reg;
    assign clipped    = clip_reg;

endmodule

>>> sv/biquad_iir_filter.sv
`timescale 1ns / 1ps
// A sample steps from the input transfer through ST_MB0, ST_ACC, ST_RND, ST_MA1,
// ST_N1, ST_MA2 and ST_N2, seven steps on the single shared 24 x 29 multiplier.
// ST_N2 holds while the output is stalled. in_ready is high only in ST_IDLE.
// The next sample is accepted while a finished result waits in the output register.
// Reset (rst_n low, async): b0 = 1.0, other coefficients and both delays zero.

module biquad_iir_filter
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [biq_pkg::ADDR_WIDTH-1:0]          paddr,
    input  logic [biq_pkg::DATA_WIDTH-1:0]          pwdata,
    output logic [biq_pkg::DATA_WIDTH-1:0]          prdata,
    output logic                                    pready,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [biq_pkg::SAMPLE_WIDTH-1:0] sample_in,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [biq_pkg::SAMPLE_WIDTH-1:0] sample_out,
    output logic                                    clipped
);
    import biq_pkg::*;

    coefs_t coefs;
    ctl_t   ctl;

    biq_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coefs   (coefs)
    );

    biq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctl       (ctl)
    );

    biq_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .coefs      (coefs),
        .sample_in  (sample_in),
        .sample_out (sample_out),
        .clipped    (clipped)
    );

endmodule

>>> sv/biq_checker.sv
`timescale 1ns / 1ps

module biq_checker
(
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    pready,
    input logic                                    in_valid,
    input logic                                    in_ready,
    input logic                                    out_valid,
    input logic                                    out_ready,
    input logic signed [biq_pkg::SAMPLE_WIDTH-1:0] sample_out,
    input logic                                    clipped
);
    import biq_pkg::*;

    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while a sample is in progress");

    a_busy_span: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> ##7 !in_ready)
        else $error("sequencer finished too early");

    a_rose_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a sample in progress");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(sample_out) && $stable(clipped)))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind biquad_iir_filter biq_checker u_biq_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .clipped    (clipped)
);
